FILE: rtl/view_frustum_cull_test_assert.svh
// Assertion macros shared by the frustum culling checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef VIEW_FRUSTUM_CULL_TEST_ASSERT_SVH
`define VIEW_FRUSTUM_CULL_TEST_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define VFCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define VFCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/vfct_pkg.sv
// Shared types and constants of the frustum culling block.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps

package vfct_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumPlanes   = 6;
  localparam int unsigned CoefW       = 32;

  // Request codes carried in the low tuser bits
  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_BUILD  = 3'd1,
    REQ_POINT  = 3'd2,
    REQ_SPHERE = 3'd3,
    REQ_BOX    = 3'd4
  } req_e;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_WRITE,
    OP_LATCH,
    OP_MUL_CLIP,
    OP_ACC_CLIP,
    OP_CLIP_ST,
    OP_RAW,
    OP_MUL_SQ,
    OP_ACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_COEF_ST,
    OP_T_INIT,
    OP_MUL_T,
    OP_T_CHK
  } op_e;

  // Controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLIP_MUL,
    ST_CLIP_ACC,
    ST_CLIP_ST,
    ST_RAW,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_COEF_ST,
    ST_T_INIT,
    ST_T_MUL,
    ST_T_ACC,
    ST_T_CHK,
    ST_FIN
  } state_e;

  // Command from controller to datapath
  typedef struct packed {
    op_e        op;
    logic [1:0] elem;      // clip column, or coefficient / axis index
    logic [1:0] row;       // clip row
    logic [1:0] k;         // product term index
    logic [2:0] plane;
    logic       out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic m_zero;          // plane normal length is zero
  } sts_t;

endpackage

FILE: rtl/view_frustum_cull_test.sv
// Top level of the frustum plane build and culling test block.
// Instantiates vfct_ctrl and vfct_datapath; uses vfct_pkg.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: req_type, matrix_sel; tdata
//  m_axis   | out | m_axis_tvalid/tready    | tdata: inside_res, degenerate
//
//  A write request gives no result; unused codes are dropped.
//  A test request uses one shared multiplier, three terms per plane.
//  A build request is paced by the bit-serial square root (32 steps) per plane
//  and the bit-serial divider (32+FRAC_BITS steps) per plane coefficient.
//  Reset clears both matrices and all planes at once; no clearing pass.
//  A finished result waits in the output register; the next request is taken
//  meanwhile and completes only once that register is free.
`timescale 1ns / 1ps

module view_frustum_cull_test #(
  parameter int unsigned FRAC_BITS = vfct_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata fields, low bit up: elem_index[3:0], elem_value[35:4], pos_x[67:36],
  // pos_y[99:68], pos_z[131:100], ext_x[162:132], ext_y[193:163],
  // ext_z[224:194], zero pad[231:225]
  input  logic [231:0] s_axis_tdata_i,
  // tuser fields, low bit up: req_type[2:0], matrix_sel[3]
  input  logic [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata fields, low bit up: inside_res[0], degenerate[1], zero pad[7:2]
  output logic [7:0]   m_axis_tdata_o
);

  vfct_pkg::cmd_t cmd;
  vfct_pkg::sts_t sts;
  logic           inside_res, degenerate;

  // Sequencer
  vfct_ctrl #(
    .FracBits(FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_req_i    (s_axis_tuser_i[2:0]),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage
  vfct_datapath #(
    .FracBits(FRAC_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (s_axis_tuser_i[2:0]),
    .matrix_sel_i (s_axis_tuser_i[3]),
    .elem_index_i (s_axis_tdata_i[3:0]),
    .elem_value_i (s_axis_tdata_i[35:4]),
    .pos_x_i      (s_axis_tdata_i[67:36]),
    .pos_y_i      (s_axis_tdata_i[99:68]),
    .pos_z_i      (s_axis_tdata_i[131:100]),
    .ext_x_i      (s_axis_tdata_i[162:132]),
    .ext_y_i      (s_axis_tdata_i[193:163]),
    .ext_z_i      (s_axis_tdata_i[224:194]),
    .inside_res_o (inside_res),
    .degenerate_o (degenerate)
  );

  assign m_axis_tdata_o = {6'b000000, degenerate, inside_res};

endmodule

FILE: rtl/vfct_datapath.sv
// Datapath: matrix and plane stores, shared multiplier, accumulator,
// square-root and divider iterations, result register. Uses vfct_pkg.
`timescale 1ns / 1ps

module vfct_datapath #(
  parameter int unsigned FracBits = vfct_pkg::FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vfct_pkg::cmd_t      cmd_i,
  output vfct_pkg::sts_t      sts_o,
  input  logic [2:0]          req_type_i,
  input  logic                matrix_sel_i,
  input  logic [3:0]          elem_index_i,
  input  logic signed [31:0]  elem_value_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_y_i,
  input  logic signed [31:0]  pos_z_i,
  input  logic [30:0]         ext_x_i,
  input  logic [30:0]         ext_y_i,
  input  logic [30:0]         ext_z_i,
  output logic                inside_res_o,
  output logic                degenerate_o
);

  localparam int unsigned CW    = vfct_pkg::CoefW;
  localparam int unsigned MulW  = CW + 1;
  localparam int unsigned ProdW = 2 * MulW;
  localparam int unsigned AccW  = ProdW + 2;
  localparam int unsigned SqW   = 2 * CW;
  localparam int unsigned DivW  = CW + FracBits;
  localparam int unsigned NP    = vfct_pkg::NumPlanes;

  // Clamp a wide signed value to the coefficient width
  function automatic logic signed [CW-1:0] sat_coef(input logic signed [AccW-1:0] v);
    logic [AccW-CW:0] top;
    top = v[AccW-1:CW-1];
    if ((&top) || !(|top)) return v[CW-1:0];
    return v[AccW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
  endfunction

  // Stores with a defined reset value
  logic signed [CW-1:0] proj_q  [16];
  logic signed [CW-1:0] view_q  [16];
  logic signed [CW-1:0] plane_q [NP][4];

  // Working registers
  vfct_pkg::req_e        req_q;
  logic signed [CW-1:0]  pos_q [3];
  logic [CW-2:0]         ext_q [3];
  logic signed [CW-1:0]  clip_q [4][4];
  logic signed [CW-1:0]  v_q [4];
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [SqW-1:0]        n_q, res_q, bit_q;
  logic [CW-1:0]         rem_q;
  logic [DivW-1:0]       num_q, quo_q;
  logic                  neg_q, pass_q, degen_q, inside_q, degen_out_q;

  // Multiplier operand select
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [CW-1:0]   coef;
  logic signed [MulW-1:0] pos_e, ext_e;

  always_comb begin
    coef  = plane_q[cmd_i.plane][cmd_i.elem];
    pos_e = {pos_q[cmd_i.elem][CW-1], pos_q[cmd_i.elem]};
    ext_e = {2'b00, ext_q[cmd_i.elem]};
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      vfct_pkg::OP_MUL_CLIP: begin
        mul_a = {view_q[{cmd_i.elem, cmd_i.k}][CW-1], view_q[{cmd_i.elem, cmd_i.k}]};
        mul_b = {proj_q[{cmd_i.k, cmd_i.row}][CW-1], proj_q[{cmd_i.k, cmd_i.row}]};
      end
      vfct_pkg::OP_MUL_SQ: begin
        mul_a = {v_q[cmd_i.elem][CW-1], v_q[cmd_i.elem]};
        mul_b = {v_q[cmd_i.elem][CW-1], v_q[cmd_i.elem]};
      end
      vfct_pkg::OP_MUL_T: begin
        mul_a = {coef[CW-1], coef};
        // box: pick the corner that maximizes the distance along this axis
        if (req_q == vfct_pkg::REQ_BOX) begin
          mul_b = coef[CW-1] ? (pos_e - ext_e) : (pos_e + ext_e);
        end else begin
          mul_b = pos_e;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sign-extended product, and its floor-shifted form
  logic signed [AccW-1:0] prod_ext, prod_sh;
  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign prod_sh  = prod_ext >>> FracBits;

  // Raw plane term: w plus or minus one clip axis
  logic [1:0]           raw_axis;
  logic                 raw_sub;
  logic signed [CW:0]   raw_sum;
  logic signed [CW-1:0] raw_w, raw_c;

  always_comb begin
    raw_axis = cmd_i.plane[2:1];
    case (cmd_i.plane)
      3'd0, 3'd3, 3'd4: raw_sub = 1'b1;
      default:          raw_sub = 1'b0;
    endcase
    raw_w   = clip_q[cmd_i.elem][3];
    raw_c   = clip_q[cmd_i.elem][raw_axis];
    raw_sum = raw_sub ? ({raw_w[CW-1], raw_w} - {raw_c[CW-1], raw_c})
                      : ({raw_w[CW-1], raw_w} + {raw_c[CW-1], raw_c});
  end

  // Square-root step
  logic [SqW-1:0] sq_t;
  assign sq_t = res_q + bit_q;

  // Divider step
  logic [CW:0] div_t, div_m;
  logic        div_ge;
  assign div_t  = {rem_q, num_q[DivW-1]};
  assign div_m  = {1'b0, res_q[CW-1:0]};
  assign div_ge = div_t >= div_m;

  // Division setup and signed quotient
  logic signed [CW-1:0] div_v;
  logic [CW-1:0]        div_mag;
  logic signed [DivW:0] quo_s;
  logic signed [AccW-1:0] quo_ext;
  assign div_v   = v_q[cmd_i.elem];
  assign div_mag = div_v[CW-1] ? (~div_v + 1'b1) : div_v;
  assign quo_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign quo_ext = {{(AccW-DivW-1){quo_s[DivW]}}, quo_s};

  // Test start value: d scaled, plus radius for a sphere
  logic signed [CW-1:0]   d_coef;
  logic signed [AccW-1:0] d_sh, r_sh;
  assign d_coef = plane_q[cmd_i.plane][3];
  assign d_sh   = {{(AccW-CW){d_coef[CW-1]}}, d_coef} <<< FracBits;
  assign r_sh   = (req_q == vfct_pkg::REQ_SPHERE)
                ? ({{(AccW-CW+1){1'b0}}, ext_q[0]} << FracBits) : '0;

  assign sts_o.m_zero = (res_q == '0);

  // Matrix and plane stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        proj_q[i] <= '0;
        view_q[i] <= '0;
      end
      for (int p = 0; p < NP; p++) begin
        for (int e = 0; e < 4; e++) plane_q[p][e] <= '0;
      end
    end else begin
      if (cmd_i.op == vfct_pkg::OP_WRITE) begin
        if (matrix_sel_i) view_q[elem_index_i] <= elem_value_i;
        else              proj_q[elem_index_i] <= elem_value_i;
      end
      if (cmd_i.op == vfct_pkg::OP_COEF_ST) begin
        plane_q[cmd_i.plane][cmd_i.elem] <= sts_o.m_zero ? '0 : sat_coef(quo_ext);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vfct_pkg::OP_LATCH: begin
        req_q    <= vfct_pkg::req_e'(req_type_i);
        pos_q[0] <= pos_x_i;
        pos_q[1] <= pos_y_i;
        pos_q[2] <= pos_z_i;
        ext_q[0] <= ext_x_i;
        ext_q[1] <= ext_y_i;
        ext_q[2] <= ext_z_i;
        acc_q    <= '0;
        pass_q   <= 1'b1;
        degen_q  <= 1'b0;
      end
      vfct_pkg::OP_MUL_CLIP, vfct_pkg::OP_MUL_SQ, vfct_pkg::OP_MUL_T: begin
        prod_q <= mul_a * mul_b;
      end
      vfct_pkg::OP_ACC_CLIP: acc_q <= acc_q + prod_sh;
      vfct_pkg::OP_ACC:      acc_q <= acc_q + prod_ext;
      vfct_pkg::OP_CLIP_ST: begin
        clip_q[cmd_i.elem][cmd_i.row] <= sat_coef(acc_q);
        acc_q <= '0;
      end
      vfct_pkg::OP_RAW: begin
        v_q[cmd_i.elem] <= sat_coef({{(AccW-CW-1){raw_sum[CW]}}, raw_sum});
      end
      vfct_pkg::OP_SQRT_INIT: begin
        n_q   <= acc_q[SqW-1:0];
        res_q <= '0;
        bit_q <= SqW'(1) << (SqW - 2);
        acc_q <= '0;
      end
      vfct_pkg::OP_SQRT_STEP: begin
        if (n_q >= sq_t) begin
          n_q   <= n_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      vfct_pkg::OP_DIV_INIT: begin
        num_q <= {div_mag, {FracBits{1'b0}}};
        rem_q <= '0;
        quo_q <= '0;
        neg_q <= div_v[CW-1];
      end
      vfct_pkg::OP_DIV_STEP: begin
        rem_q <= div_ge ? CW'(div_t - div_m) : div_t[CW-1:0];
        quo_q <= {quo_q[DivW-2:0], div_ge};
        num_q <= num_q << 1;
      end
      vfct_pkg::OP_COEF_ST: degen_q <= degen_q | sts_o.m_zero;
      vfct_pkg::OP_T_INIT:  acc_q <= d_sh + r_sh;
      vfct_pkg::OP_T_CHK:   pass_q <= pass_q & ~acc_q[AccW-1] & (|acc_q);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      inside_q    <= (req_q != vfct_pkg::REQ_BUILD) & pass_q;
      degen_out_q <= (req_q == vfct_pkg::REQ_BUILD) & degen_q;
    end
  end

  assign inside_res_o = inside_q;
  assign degenerate_o = degen_out_q;

endmodule

FILE: rtl/vfct_ctrl.sv
// Controller: sequences build and test requests over the datapath and
// owns both handshakes. Uses vfct_pkg.
`timescale 1ns / 1ps

module vfct_ctrl #(
  parameter int unsigned FracBits = vfct_pkg::FracBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     in_req_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  vfct_pkg::sts_t sts_i,
  output vfct_pkg::cmd_t cmd_o
);

  localparam int unsigned DivW   = vfct_pkg::CoefW + FracBits;
  localparam int unsigned SqSteps = vfct_pkg::CoefW;
  localparam int unsigned CntW   = $clog2(DivW);
  localparam logic [2:0]  LastPlane = 3'(vfct_pkg::NumPlanes - 1);

  vfct_pkg::state_e state_q, state_d;
  logic [1:0]       elem_q, elem_d, row_q, row_d, k_q, k_d;
  logic [2:0]       plane_q, plane_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             in_accept, fin_go;
  vfct_pkg::req_e   req_sel;

  assign req_sel     = vfct_pkg::req_e'(in_req_i);
  assign in_ready_o  = (state_q == vfct_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign fin_go      = (state_q == vfct_pkg::ST_FIN) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Next state and loop counters
  always_comb begin
    state_d = state_q;
    elem_d  = elem_q;
    row_d   = row_q;
    k_d     = k_q;
    plane_d = plane_q;
    cnt_d   = cnt_q;
    case (state_q)
      vfct_pkg::ST_IDLE: begin
        elem_d  = '0;
        row_d   = '0;
        k_d     = '0;
        plane_d = '0;
        if (in_accept) begin
          case (req_sel)
            vfct_pkg::REQ_BUILD: state_d = vfct_pkg::ST_CLIP_MUL;
            vfct_pkg::REQ_POINT, vfct_pkg::REQ_SPHERE, vfct_pkg::REQ_BOX:
              state_d = vfct_pkg::ST_T_INIT;
            default: state_d = vfct_pkg::ST_IDLE;
          endcase
        end
      end
      vfct_pkg::ST_CLIP_MUL: state_d = vfct_pkg::ST_CLIP_ACC;
      vfct_pkg::ST_CLIP_ACC: begin
        if (k_q == 2'd3) begin
          state_d = vfct_pkg::ST_CLIP_ST;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = vfct_pkg::ST_CLIP_MUL;
        end
      end
      vfct_pkg::ST_CLIP_ST: begin
        k_d = '0;
        if (row_q == 2'd3) begin
          row_d = '0;
          if (elem_q == 2'd3) begin
            elem_d  = '0;
            plane_d = '0;
            state_d = vfct_pkg::ST_RAW;
          end else begin
            elem_d  = elem_q + 2'd1;
            state_d = vfct_pkg::ST_CLIP_MUL;
          end
        end else begin
          row_d   = row_q + 2'd1;
          state_d = vfct_pkg::ST_CLIP_MUL;
        end
      end
      vfct_pkg::ST_RAW: begin
        if (elem_q == 2'd3) begin
          elem_d  = '0;
          state_d = vfct_pkg::ST_SQ_MUL;
        end else begin
          elem_d = elem_q + 2'd1;
        end
      end
      vfct_pkg::ST_SQ_MUL: state_d = vfct_pkg::ST_SQ_ACC;
      vfct_pkg::ST_SQ_ACC: begin
        if (elem_q == 2'd2) begin
          elem_d  = '0;
          state_d = vfct_pkg::ST_SQRT_INIT;
        end else begin
          elem_d  = elem_q + 2'd1;
          state_d = vfct_pkg::ST_SQ_MUL;
        end
      end
      vfct_pkg::ST_SQRT_INIT: begin
        cnt_d   = '0;
        state_d = vfct_pkg::ST_SQRT;
      end
      vfct_pkg::ST_SQRT: begin
        if (cnt_q == CntW'(SqSteps - 1)) begin
          state_d = vfct_pkg::ST_DIV_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      vfct_pkg::ST_DIV_INIT: begin
        cnt_d   = '0;
        // zero-length normal: coefficients are stored as zero directly
        state_d = sts_i.m_zero ? vfct_pkg::ST_COEF_ST : vfct_pkg::ST_DIV;
      end
      vfct_pkg::ST_DIV: begin
        if (cnt_q == CntW'(DivW - 1)) begin
          state_d = vfct_pkg::ST_COEF_ST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      vfct_pkg::ST_COEF_ST: begin
        if (elem_q == 2'd3) begin
          elem_d = '0;
          if (plane_q == LastPlane) begin
            state_d = vfct_pkg::ST_FIN;
          end else begin
            plane_d = plane_q + 3'd1;
            state_d = vfct_pkg::ST_RAW;
          end
        end else begin
          elem_d  = elem_q + 2'd1;
          state_d = vfct_pkg::ST_DIV_INIT;
        end
      end
      vfct_pkg::ST_T_INIT: state_d = vfct_pkg::ST_T_MUL;
      vfct_pkg::ST_T_MUL:  state_d = vfct_pkg::ST_T_ACC;
      vfct_pkg::ST_T_ACC: begin
        if (elem_q == 2'd2) begin
          elem_d  = '0;
          state_d = vfct_pkg::ST_T_CHK;
        end else begin
          elem_d  = elem_q + 2'd1;
          state_d = vfct_pkg::ST_T_MUL;
        end
      end
      vfct_pkg::ST_T_CHK: begin
        if (plane_q == LastPlane) begin
          state_d = vfct_pkg::ST_FIN;
        end else begin
          plane_d = plane_q + 3'd1;
          state_d = vfct_pkg::ST_T_INIT;
        end
      end
      vfct_pkg::ST_FIN: begin
        if (fin_go) state_d = vfct_pkg::ST_IDLE;
      end
      default: state_d = vfct_pkg::ST_IDLE;
    endcase
  end

  // Datapath command
  always_comb begin
    cmd_o.elem     = elem_q;
    cmd_o.row      = row_q;
    cmd_o.k        = k_q;
    cmd_o.plane    = plane_q;
    cmd_o.out_load = fin_go;
    case (state_q)
      vfct_pkg::ST_IDLE: begin
        if (!in_accept) begin
          cmd_o.op = vfct_pkg::OP_NOP;
        end else begin
          case (req_sel)
            vfct_pkg::REQ_WRITE: cmd_o.op = vfct_pkg::OP_WRITE;
            vfct_pkg::REQ_BUILD, vfct_pkg::REQ_POINT, vfct_pkg::REQ_SPHERE,
            vfct_pkg::REQ_BOX:   cmd_o.op = vfct_pkg::OP_LATCH;
            default:             cmd_o.op = vfct_pkg::OP_NOP;
          endcase
        end
      end
      vfct_pkg::ST_CLIP_MUL:  cmd_o.op = vfct_pkg::OP_MUL_CLIP;
      vfct_pkg::ST_CLIP_ACC:  cmd_o.op = vfct_pkg::OP_ACC_CLIP;
      vfct_pkg::ST_CLIP_ST:   cmd_o.op = vfct_pkg::OP_CLIP_ST;
      vfct_pkg::ST_RAW:       cmd_o.op = vfct_pkg::OP_RAW;
      vfct_pkg::ST_SQ_MUL:    cmd_o.op = vfct_pkg::OP_MUL_SQ;
      vfct_pkg::ST_SQ_ACC:    cmd_o.op = vfct_pkg::OP_ACC;
      vfct_pkg::ST_SQRT_INIT: cmd_o.op = vfct_pkg::OP_SQRT_INIT;
      vfct_pkg::ST_SQRT:      cmd_o.op = vfct_pkg::OP_SQRT_STEP;
      vfct_pkg::ST_DIV_INIT:  cmd_o.op = vfct_pkg::OP_DIV_INIT;
      vfct_pkg::ST_DIV:       cmd_o.op = vfct_pkg::OP_DIV_STEP;
      vfct_pkg::ST_COEF_ST:   cmd_o.op = vfct_pkg::OP_COEF_ST;
      vfct_pkg::ST_T_INIT:    cmd_o.op = vfct_pkg::OP_T_INIT;
      vfct_pkg::ST_T_MUL:     cmd_o.op = vfct_pkg::OP_MUL_T;
      vfct_pkg::ST_T_ACC:     cmd_o.op = vfct_pkg::OP_ACC;
      vfct_pkg::ST_T_CHK:     cmd_o.op = vfct_pkg::OP_T_CHK;
      default:                cmd_o.op = vfct_pkg::OP_NOP;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (fin_go)                     out_valid_d = 1'b1;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfct_pkg::ST_IDLE;
      elem_q      <= '0;
      row_q       <= '0;
      k_q         <= '0;
      plane_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      elem_q      <= elem_d;
      row_q       <= row_d;
      k_q         <= k_d;
      plane_q     <= plane_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/vfct_checker.sv
// Port-level checker for the frustum culling block, bound to the top level.
// Depends on view_frustum_cull_test_assert.svh.
`timescale 1ns / 1ps
`include "view_frustum_cull_test_assert.svh"

module vfct_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [231:0] s_axis_tdata_i,
  input logic [3:0]   s_axis_tuser_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [7:0]   m_axis_tdata_o
);

  logic in_acc, wr_acc, build_acc;
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_acc    = in_acc && (s_axis_tuser_i[2:0] == vfct_pkg::REQ_WRITE);
  assign build_acc = in_acc && (s_axis_tuser_i[2:0] == vfct_pkg::REQ_BUILD);

  // a stalled result holds
  `VFCT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  // a result is either a test answer or a build flag, never both
  `VFCT_ASSERT_IMP(a_flags_excl, clk_i, rst_ni, m_axis_tvalid_o, !(m_axis_tdata_o[0] && m_axis_tdata_o[1]), "inside and degenerate both set")
  // a build request occupies the sequencer
  `VFCT_ASSERT_NXT(a_build_busy, clk_i, rst_ni, build_acc, !s_axis_tready_o, "ready right after build request")
  // a matrix write leaves the input ready again in the next cycle
  `VFCT_ASSERT_NXT(a_write_free, clk_i, rst_ni, wr_acc, s_axis_tready_o, "not ready after write request")

endmodule

bind view_frustum_cull_test vfct_checker u_vfct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
